[hw/rtl/sem_pkg.sv]
// Shared types and constants for the RGB Sobel edge magnitude block.
package sem_pkg;

    // Default frame limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // Configuration register layout
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_RESET = 1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Input operation codes
    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    // Magnitude limits
    localparam logic [7:0]  PIX_MAX   = 8'd255;
    localparam logic [20:0] SAT_LIMIT = 21'd65281;

    // Queue between the front and the back
    localparam int Q_DEPTH = 2;
    localparam int Q_PW    = 1;

    // One pixel: red in the low byte, blue in the high byte
    typedef logic [23:0] pixel_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       last_of_frame;
    } out_item_t;

    // Masked 3x3 neighbourhood, tap[row][column], row 0 top, column 0 left
    typedef struct packed {
        logic                  last;
        pixel_t [2:0][2:0]     tap;
    } window_t;

endpackage

[hw/rtl/sem_ram.sv]
// Generic simple dual-port RAM with registered read.
module sem_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/sem_queue.sv]
// Two-entry queue of neighbourhood requests between front and back.
module sem_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sem_pkg::window_t wdata,
    output logic             space,
    input  logic             pop,
    output logic             valid,
    output sem_pkg::window_t rdata
);

    sem_pkg::window_t             mem_reg [sem_pkg::Q_DEPTH];
    logic [sem_pkg::Q_PW-1:0]     wr_ptr_reg;
    logic [sem_pkg::Q_PW-1:0]     rd_ptr_reg;
    logic [sem_pkg::Q_PW:0]       count_reg;

    assign space = (count_reg != (sem_pkg::Q_PW + 1)'(sem_pkg::Q_DEPTH));
    assign valid = (count_reg != '0);
    assign rdata = mem_reg[rd_ptr_reg];

    // Store incoming requests
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/sem_front.sv]
// Front end: line stores, 3x3 window, frame counters and neighbourhood masking.
module sem_front #(
    parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [sem_pkg::CFG_W-1:0] image_width,
    input  logic [sem_pkg::CFG_W-1:0] image_height,
    input  logic                      push,
    output logic                      full,
    input  sem_pkg::in_item_t         item,
    input  logic                      q_space,
    output logic                      q_push,
    output sem_pkg::window_t          q_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int EW = $clog2(MAX_WIDTH + 1);
    localparam int EH = $clog2(MAX_HEIGHT + 1);

    typedef enum logic [1:0] {
        F_IDLE  = 2'b01,
        F_APPLY = 2'b10
    } fstate_t;

    fstate_t           state_reg, state_next;
    logic [CW-1:0]     ic_reg;
    logic [1:0]        ir_reg;
    logic [CW-1:0]     oc_reg;
    logic [RW-1:0]     or_reg;
    sem_pkg::pixel_t   px_reg;
    sem_pkg::pixel_t   taps_reg [3][3];

    logic [EW-1:0]     w_eff;
    logic [EH-1:0]     h_eff;
    logic              accept;
    logic              apply;
    logic              fire;
    logic              ic_wrap;
    logic              oc_end;
    logic              or_end;
    sem_pkg::pixel_t   top_rd;
    sem_pkg::pixel_t   mid_rd;
    sem_pkg::pixel_t   top;
    sem_pkg::pixel_t   mid;
    sem_pkg::pixel_t   col_in [3];

    // Effective frame size
    always_comb
    begin
        if (image_width == '0)
        begin
            w_eff = EW'(1);
        end
        else if (32'(image_width) > MAX_WIDTH)
        begin
            w_eff = EW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = EW'(image_width);
        end
        if (image_height == '0)
        begin
            h_eff = EH'(1);
        end
        else if (32'(image_height) > MAX_HEIGHT)
        begin
            h_eff = EH'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = EH'(image_height);
        end
    end

    assign full   = (state_reg != F_IDLE) || !q_space;
    assign accept = push && !full;
    assign apply  = (state_reg == F_APPLY);

    // Line stores: read on accept, write back in the apply cycle
    sem_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_upper (
        .clk   (clk),
        .we    (apply),
        .waddr (ic_reg),
        .wdata (mid),
        .re    (accept),
        .raddr (ic_reg),
        .rdata (top_rd)
    );

    sem_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_middle (
        .clk   (clk),
        .we    (apply),
        .waddr (ic_reg),
        .wdata (px_reg),
        .re    (accept),
        .raddr (ic_reg),
        .rdata (mid_rd)
    );

    // Gate reads of rows not yet seen in this frame
    assign top = (ir_reg >= 2'd2) ? top_rd : '0;
    assign mid = (ir_reg >= 2'd1) ? mid_rd : '0;
    assign col_in[0] = top;
    assign col_in[1] = mid;
    assign col_in[2] = px_reg;

    assign fire    = (ir_reg >= 2'd2) || ((ir_reg == 2'd1) && (ic_reg != '0));
    assign ic_wrap = ((EW + 1)'(ic_reg) + (EW + 1)'(1)) >= (EW + 1)'(w_eff);
    assign oc_end  = ((EW + 1)'(oc_reg) + (EW + 1)'(1)) >= (EW + 1)'(w_eff);
    assign or_end  = ((EH + 1)'(or_reg) + (EH + 1)'(1)) >= (EH + 1)'(h_eff);

    // Build the masked neighbourhood; column 2 is empty at the row start
    always_comb
    begin
        q_data.last = fire && oc_end && or_end;
        for (int r = 0; r < 3; r++)
        begin
            q_data.tap[r][0] = taps_reg[r][1];
            q_data.tap[r][1] = taps_reg[r][2];
            q_data.tap[r][2] = (ic_reg == '0) ? '0 : col_in[r];
            if (oc_reg == '0)
            begin
                q_data.tap[r][0] = '0;
            end
            if (oc_end)
            begin
                q_data.tap[r][2] = '0;
            end
        end
        for (int c = 0; c < 3; c++)
        begin
            if (or_reg == '0)
            begin
                q_data.tap[0][c] = '0;
            end
            if (or_end)
            begin
                q_data.tap[2][c] = '0;
            end
        end
    end

    assign q_push = apply && fire;

    // Sequence: accept, then apply
    always_comb
    begin
        case (state_reg)
            F_IDLE:  state_next = accept ? F_APPLY : F_IDLE;
            F_APPLY: state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // Hold the incoming pixel; a drain enters as zero
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (item.operation == sem_pkg::OP_DRAIN)
            begin
                px_reg <= '0;
            end
            else
            begin
                px_reg <= {item.in_blue, item.in_green, item.in_red};
            end
        end
    end

    // Advance window and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            ic_reg    <= '0;
            ir_reg    <= '0;
            oc_reg    <= '0;
            or_reg    <= '0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    taps_reg[r][c] <= '0;
                end
            end
        end
        else
        begin
            state_reg <= state_next;
            if (apply)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    taps_reg[r][0] <= taps_reg[r][1];
                    taps_reg[r][1] <= taps_reg[r][2];
                    taps_reg[r][2] <= col_in[r];
                end
                if (fire && oc_end && or_end)
                begin
                    // Frame done: restart all positions
                    ic_reg <= '0;
                    ir_reg <= '0;
                    oc_reg <= '0;
                    or_reg <= '0;
                end
                else
                begin
                    if (ic_wrap)
                    begin
                        ic_reg <= '0;
                        if (ir_reg != 2'd2)
                        begin
                            ir_reg <= ir_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        ic_reg <= ic_reg + 1'b1;
                    end
                    if (fire)
                    begin
                        if (oc_end)
                        begin
                            oc_reg <= '0;
                            or_reg <= or_reg + 1'b1;
                        end
                        else
                        begin
                            oc_reg <= oc_reg + 1'b1;
                        end
                    end
                end
            end
        end
    end

endmodule

[hw/rtl/sem_back.sv]
// Back end: Sobel sums, squares, digit-serial square root stages, rounding.
module sem_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  sem_pkg::window_t   q_data,
    output logic               q_pop,
    output logic               empty,
    input  logic               pop,
    output sem_pkg::out_item_t result
);

    localparam int NSQ = 9;

    logic              adv;
    logic              v0_reg, v1_reg;
    logic              last0_reg, last1_reg;
    logic [9:0]        ax_reg [3];
    logic [9:0]        ay_reg [3];
    logic [20:0]       s_reg [3];
    logic              sv_reg [NSQ];
    logic              slast_reg [NSQ];
    logic              sat_reg [3][NSQ];
    logic [15:0]       rad_reg [3][NSQ];
    logic [9:0]        rem_reg [3][NSQ];
    logic [7:0]        root_reg [3][NSQ];
    logic              out_v_reg;
    sem_pkg::out_item_t result_reg;
    logic [7:0]        mag [3];

    // The whole pipeline moves unless a finished result is stuck
    assign adv   = !out_v_reg || pop;
    assign q_pop = adv && q_valid;
    assign empty = !out_v_reg;
    assign result = result_reg;

    genvar ch, j;
    generate
        for (ch = 0; ch < 3; ch++)
        begin : g_lane
            logic [11:0] p [3][3];
            logic [11:0] gx, gy;

            // Sobel sums in 12-bit two's complement
            always_comb
            begin
                for (int r = 0; r < 3; r++)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        p[r][c] = 12'(q_data.tap[r][c][8*ch +: 8]);
                    end
                end
                gx = p[0][2] - p[0][0] + ((p[1][2] - p[1][0]) << 1) + p[2][2] - p[2][0];
                gy = p[2][0] + (p[2][1] << 1) + p[2][2] - p[0][0] - (p[0][1] << 1) - p[0][2];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    ax_reg[ch] <= gx[11] ? 10'(-gx) : gx[9:0];
                    ay_reg[ch] <= gy[11] ? 10'(-gy) : gy[9:0];
                    s_reg[ch]  <= 21'(ax_reg[ch] * ax_reg[ch]) + 21'(ay_reg[ch] * ay_reg[ch]);
                    sat_reg[ch][0]  <= (s_reg[ch] >= sem_pkg::SAT_LIMIT);
                    rad_reg[ch][0]  <= s_reg[ch][15:0];
                    rem_reg[ch][0]  <= '0;
                    root_reg[ch][0] <= '0;
                end
            end

            // One root bit per stage
            for (j = 1; j < NSQ; j++)
            begin : g_step
                logic [11:0] cur, sub;
                logic        ge;

                assign cur = {rem_reg[ch][j-1], rad_reg[ch][j-1][15:14]};
                assign sub = {2'b00, root_reg[ch][j-1], 2'b01};
                assign ge  = (cur >= sub);

                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        sat_reg[ch][j]  <= sat_reg[ch][j-1];
                        rad_reg[ch][j]  <= {rad_reg[ch][j-1][13:0], 2'b00};
                        rem_reg[ch][j]  <= ge ? 10'(cur - sub) : 10'(cur);
                        root_reg[ch][j] <= {root_reg[ch][j-1][6:0], ge};
                    end
                end
            end

            // Round to nearest and clamp
            logic [8:0] rounded;
            assign rounded = {1'b0, root_reg[ch][NSQ-1]}
                           + 9'(rem_reg[ch][NSQ-1] > {2'b00, root_reg[ch][NSQ-1]});
            assign mag[ch] = (sat_reg[ch][NSQ-1] || rounded[8]) ? sem_pkg::PIX_MAX
                                                                 : rounded[7:0];
        end

        for (j = 1; j < NSQ; j++)
        begin : g_flags
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sv_reg[j] <= 1'b0;
                end
                else if (adv)
                begin
                    sv_reg[j] <= sv_reg[j-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    slast_reg[j] <= slast_reg[j-1];
                end
            end
        end
    endgenerate

    // Head of the pipeline and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            sv_reg[0] <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg    <= q_valid;
            v1_reg    <= v0_reg;
            sv_reg[0] <= v1_reg;
            out_v_reg <= sv_reg[NSQ-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            last0_reg    <= q_data.last;
            last1_reg    <= last0_reg;
            slast_reg[0] <= last1_reg;
            result_reg.out_red       <= mag[0];
            result_reg.out_green     <= mag[1];
            result_reg.out_blue      <= mag[2];
            result_reg.last_of_frame <= slast_reg[NSQ-1];
        end
    end

endmodule

[hw/rtl/sobel_edge_magnitude_rgb.sv]
// Top level of the streaming 3x3 Sobel edge magnitude block for RGB pixels.
//
// Input queue side: an item (pixel or drain) is taken when push is high and
// full is low. Pixels arrive in raster order; drain items act as zero pixels
// and push out the final width+1 results of a frame.
// Result queue side: while empty is low, result holds the oldest magnitude
// triple; it is taken when pop is high. last_of_frame marks the frame's end.
// Configuration: cfg_write with cfg_index 0 sets the width, 1 the height;
// write only while the block is idle.
// Items are not taken back to back: the line-store read happens in the accept
// cycle and the write-back in the following cycle, during which full is high.
// A result reaches the result ports once the item that completes its
// neighbourhood has passed the apply cycle, the request queue, Sobel, square,
// the nine root stages and the output register.
// Reset clears all positions, the window and the queues; line stores need
// no clearing. When pop stays low the back pipeline holds, the two-entry
// queue fills, and then full rises to hold off new items.
module sobel_edge_magnitude_rgb #(
    parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  sem_pkg::in_item_t             item,
    output logic                          empty,
    input  logic                          pop,
    output sem_pkg::out_item_t            result,
    input  logic                          cfg_write,
    input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sem_pkg::CFG_W-1:0]     cfg_data
);

    logic [sem_pkg::CFG_W-1:0] width_reg;
    logic [sem_pkg::CFG_W-1:0] height_reg;
    logic                      q_push, q_space, q_pop, q_valid;
    sem_pkg::window_t          q_wdata, q_rdata;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= sem_pkg::CFG_W'(sem_pkg::CFG_RESET);
            height_reg <= sem_pkg::CFG_W'(sem_pkg::CFG_RESET);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sem_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                sem_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    sem_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (width_reg),
        .image_height (height_reg),
        .push         (push),
        .full         (full),
        .item         (item),
        .q_space      (q_space),
        .q_push       (q_push),
        .q_data       (q_wdata)
    );

    sem_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .space (q_space),
        .pop   (q_pop),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    sem_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    // The front never pushes a request without room in the queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> q_space)
        else $error("request pushed into a full queue");

    // An accepted item keeps the front busy for the apply cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> full)
        else $error("front accepted a second item too early");

    // The back only takes requests that are present
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("request popped from an empty queue");

endmodule

[tb/sobel_edge_magnitude_rgb_tb.sv]
// Self-checking testbench for the RGB Sobel edge magnitude block.
module sobel_edge_magnitude_rgb_tb;

    import sem_pkg::*;

    localparam int QUIET_CYCLES = 40;
    localparam int NO_IDLE_FROM = 600;
    localparam int NO_IDLE_TO   = 1400;

    typedef struct {
        bit               is_cfg;
        cfg_reg_t         reg_sel;
        logic [CFG_W-1:0] reg_value;
        in_item_t         req;
    } pending_t;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    in_item_t           item;
    logic               empty;
    logic               pop;
    out_item_t          result;
    logic               cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    // Stimulus and expected results
    pending_t  pending_reqs[$];
    out_item_t expected_pixels[$];
    int        errors;
    int        cycle_count;
    int        quiet_count;
    int        frames_sent;
    int        results_seen;

    // Predictor state
    pixel_t      upper_line[MAX_WIDTH];
    pixel_t      middle_line[MAX_WIDTH];
    pixel_t      taps[3][3];
    int          in_col, in_row, out_col, out_row;
    logic [10:0] width_reg, height_reg;

    sobel_edge_magnitude_rgb DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Rounded square root of Gx^2 + Gy^2, clamped to the pixel range
    function automatic logic [7:0] edge_mag(int gx, int gy);
        int s, n, t, b;
        s = gx * gx + gy * gy;
        n = 0;
        if (s >= 65281)
            return PIX_MAX;
        for (b = 8; b >= 0; b--)
        begin
            t = n | (1 << b);
            if (t * t <= s)
                n = t;
        end
        if (s > n * n + n)
            n++;
        if (n > 255)
            n = 255;
        return n[7:0];
    endfunction

    // Build the masked neighbourhood and apply both kernels per channel
    function automatic out_item_t sobel_of_window(int first_col, bit right_zero,
                                                  int w, int h);
        pixel_t    nb[3][3];
        int        v[3][3];
        int        r, c, src, ch, gx, gy;
        out_item_t res;
        logic [7:0] mag[3];
        for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
            begin
                src = first_col + c;
                nb[r][c] = (src >= 0 && src <= 2) ? taps[r][src] : '0;
                if ((c == 2 && right_zero) || (c == 0 && out_col == 0) ||
                    (c == 2 && out_col + 1 >= w) || (r == 0 && out_row == 0) ||
                    (r == 2 && out_row + 1 >= h))
                    nb[r][c] = '0;
            end
        for (ch = 0; ch < 3; ch++)
        begin
            for (r = 0; r < 3; r++)
                for (c = 0; c < 3; c++)
                    v[r][c] = int'(nb[r][c][8*ch +: 8]);
            gx = -v[0][0] + v[0][2] - 2 * v[1][0] + 2 * v[1][2] - v[2][0] + v[2][2];
            gy = -v[0][0] - 2 * v[0][1] - v[0][2] + v[2][0] + 2 * v[2][1] + v[2][2];
            mag[ch] = edge_mag(gx, gy);
        end
        res.out_red       = mag[0];
        res.out_green     = mag[1];
        res.out_blue      = mag[2];
        res.last_of_frame = 1'b0;
        return res;
    endfunction

    // Advance the predictor by one request; queue a result when one is due
    function automatic void predict_request(in_item_t req);
        int        w, h, r;
        bit        fire, in_range;
        pixel_t    px, top, mid;
        out_item_t res;
        w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
        h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
        in_range = in_col < MAX_WIDTH;
        fire = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        px  = (req.operation == OP_PIXEL) ? {req.in_blue, req.in_green, req.in_red} : '0;
        top = (in_range && in_row >= 2) ? upper_line[in_col] : '0;
        mid = (in_range && in_row >= 1) ? middle_line[in_col] : '0;
        if (fire && in_col == 0)
            res = sobel_of_window(1, 1'b1, w, h);
        for (r = 0; r < 3; r++)
        begin
            taps[r][0] = taps[r][1];
            taps[r][1] = taps[r][2];
        end
        taps[0][2] = top;
        taps[1][2] = mid;
        taps[2][2] = px;
        if (in_range)
        begin
            upper_line[in_col]  = mid;
            middle_line[in_col] = px;
        end
        if (fire && in_col != 0)
            res = sobel_of_window(0, 1'b0, w, h);
        if (in_col + 1 >= w)
        begin
            in_col = 0;
            if (in_row < 2047)
                in_row++;
        end
        else
            in_col++;
        if (!fire)
            return;
        res.last_of_frame = 1'b0;
        if (out_col + 1 >= w)
        begin
            if (out_row + 1 >= h)
            begin
                res.last_of_frame = 1'b1;
                in_col = 0;
                in_row = 0;
                out_col = 0;
                out_row = 0;
            end
            else
            begin
                out_col = 0;
                out_row++;
            end
        end
        else
            out_col++;
        expected_pixels.push_back(res);
    endfunction

    function automatic bit idle_now();
        if (cycle_count >= NO_IDLE_FROM && cycle_count < NO_IDLE_TO)
            return 1'b0;
        return $urandom_range(99) < 6;
    endfunction

    // Driver: predict accepted requests, then present the next one
    always @(posedge clk or negedge rst_n)
    begin
        bit       next_push;
        bit       next_cfg;
        in_item_t next_item;
        if (!rst_n)
        begin
            push      <= 1'b0;
            item      <= '0;
            cfg_write <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
        end
        else
        begin
            next_push = 1'b0;
            next_cfg  = 1'b0;
            next_item = item;
            cycle_count++;
            if (push && !full)
            begin
                predict_request(pending_reqs[0].req);
                void'(pending_reqs.pop_front());
                quiet_count = 0;
            end
            else if (expected_pixels.size() != 0)
                quiet_count = 0;
            else
                quiet_count++;
            if (pending_reqs.size() != 0)
            begin
                if (pending_reqs[0].is_cfg)
                begin
                    // Only reconfigure once the block has fully drained
                    if (!push && !cfg_write && quiet_count >= QUIET_CYCLES)
                    begin
                        next_cfg = 1'b1;
                        cfg_index <= pending_reqs[0].reg_sel;
                        cfg_data  <= pending_reqs[0].reg_value;
                        if (pending_reqs[0].reg_sel == REG_IMAGE_WIDTH)
                            width_reg = pending_reqs[0].reg_value;
                        else
                            height_reg = pending_reqs[0].reg_value;
                        void'(pending_reqs.pop_front());
                    end
                end
                else if (!idle_now())
                begin
                    next_push = 1'b1;
                    next_item = pending_reqs[0].req;
                end
            end
            push      <= next_push;
            item      <= next_item;
            cfg_write <= next_cfg;
        end
    end

    // Monitor: stall at random and check each accepted result
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_px;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                results_seen++;
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, result);
                    errors++;
                end
                else
                begin
                    exp_px = expected_pixels.pop_front();
                    if (result.out_red !== exp_px.out_red)
                    begin
                        $display("%0t: out_red expected %0d actual %0d",
                                 $time, exp_px.out_red, result.out_red);
                        errors++;
                    end
                    if (result.out_green !== exp_px.out_green)
                    begin
                        $display("%0t: out_green expected %0d actual %0d",
                                 $time, exp_px.out_green, result.out_green);
                        errors++;
                    end
                    if (result.out_blue !== exp_px.out_blue)
                    begin
                        $display("%0t: out_blue expected %0d actual %0d",
                                 $time, exp_px.out_blue, result.out_blue);
                        errors++;
                    end
                    if (result.last_of_frame !== exp_px.last_of_frame)
                    begin
                        $display("%0t: last_of_frame expected %0d actual %0d",
                                 $time, exp_px.last_of_frame, result.last_of_frame);
                        errors++;
                    end
                end
            end
            pop <= !idle_now();
        end
    end

    task automatic add_cfg(cfg_reg_t sel, int value);
        pending_t p;
        p.is_cfg    = 1'b1;
        p.reg_sel   = sel;
        p.reg_value = value[CFG_W-1:0];
        p.req       = '0;
        pending_reqs.push_back(p);
    endtask

    task automatic add_request(op_t op, logic [23:0] rgb);
        pending_t p;
        p.is_cfg         = 1'b0;
        p.reg_sel        = REG_IMAGE_WIDTH;
        p.reg_value      = '0;
        p.req.operation  = op;
        p.req.in_red     = rgb[7:0];
        p.req.in_green   = rgb[15:8];
        p.req.in_blue    = rgb[23:16];
        pending_reqs.push_back(p);
    endtask

    // One whole random frame: W*H slots plus W+1 flushing requests
    task automatic add_frame(int wreg, int hreg);
        int w, h, k;
        w = (wreg == 0) ? 1 : (wreg > MAX_WIDTH) ? MAX_WIDTH : wreg;
        h = (hreg == 0) ? 1 : (hreg > MAX_HEIGHT) ? MAX_HEIGHT : hreg;
        add_cfg(REG_IMAGE_WIDTH, wreg);
        add_cfg(REG_IMAGE_HEIGHT, hreg);
        for (k = 0; k < w * h + w + 1; k++)
        begin
            // early drains inside the frame, extra pixels past its end
            if ((k < w * h) == ($urandom_range(9) != 0))
                add_request(OP_PIXEL, $urandom_range(24'hFFFFFF));
            else
                add_request(OP_DRAIN, $urandom_range(24'hFFFFFF));
        end
        frames_sent++;
    endtask

    initial
    begin
        int k;
        errors       = 0;
        cycle_count  = 0;
        quiet_count  = 0;
        frames_sent  = 0;
        results_seen = 0;
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
        width_reg  = CFG_RESET;
        height_reg = CFG_RESET;
        foreach (taps[r, c])
            taps[r][c] = '0;
        foreach (upper_line[i])
        begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        rst_n = 1'b0;
        push = 1'b0;
        pop  = 1'b0;
        item = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        // Directed 3x3 frame: hard edges, saturation, zeros and an early drain
        add_cfg(REG_IMAGE_WIDTH, 3);
        add_cfg(REG_IMAGE_HEIGHT, 3);
        add_request(OP_PIXEL, 24'hFFFFFF);
        add_request(OP_PIXEL, 24'h000000);
        add_request(OP_PIXEL, 24'hFFFFFF);
        add_request(OP_PIXEL, 24'h0000FF);
        add_request(OP_DRAIN, 24'hFFFFFF);
        add_request(OP_PIXEL, 24'hFF00FF);
        add_request(OP_PIXEL, 24'hFFFFFF);
        add_request(OP_PIXEL, 24'h00FF00);
        add_request(OP_PIXEL, 24'hFFFFFF);
        add_request(OP_DRAIN, 24'h000000);
        add_request(OP_PIXEL, 24'hFFFFFF);
        add_request(OP_DRAIN, 24'h000000);
        add_request(OP_DRAIN, 24'h000000);
        frames_sent++;

        // Zero sizes act as one: 0x0, the smallest legal frame 1x1, then 0x3 and 2x0
        add_frame(0, 0);
        add_frame(1, 1);
        add_frame(0, 3);
        add_frame(2, 0);

        // Random small frames
        k = 0;
        while (k < 520)
        begin
            int wr, hr;
            wr = $urandom_range(1, 12);
            hr = $urandom_range(1, 8);
            add_frame(wr, hr);
            k += wr * hr + wr + 1;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_reqs.size() == 0 && expected_pixels.size() == 0);
        repeat (QUIET_CYCLES) @(posedge clk);
        $display("Covered %0d frames, %0d results checked, sizes from 1x1 up to 12x8.",
                 frames_sent, results_seen);
        if (errors == 0 && expected_pixels.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog
    initial
    begin
        #3000000;
        $display("Timed out with %0d requests pending", pending_reqs.size());
        $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/sem_pkg.sv
hw/rtl/sem_ram.sv
hw/rtl/sem_queue.sv
hw/rtl/sem_front.sv
hw/rtl/sem_back.sv
hw/rtl/sobel_edge_magnitude_rgb.sv
tb/sobel_edge_magnitude_rgb_tb.sv
